### design/jec_pkg.sv
// ============================================================================
// jec_pkg
// Shared types and constants for the JSON envelope byte checker.
// ============================================================================
package jec_pkg;

    localparam int DocCountWidth  = 25;
    localparam int StrCountWidth  = 17;
    localparam int DepthWidth     = 9;
    localparam int MaxDocWidth    = 24;
    localparam int MaxStrWidth    = 16;
    localparam int MaxDepthWidth  = 8;
    localparam int CfgDataWidth   = 24;
    localparam int CfgIndexWidth  = 2;

    localparam logic [MaxDocWidth-1:0]   MaxDocReset   = 24'd1048576;
    localparam logic [MaxStrWidth-1:0]   MaxStrReset   = 16'd4096;
    localparam logic [MaxDepthWidth-1:0] MaxDepthReset = 8'd64;

    localparam logic [7:0] CharNul       = 8'h00;
    localparam logic [7:0] CharBackslash = 8'h5C;
    localparam logic [7:0] CharQuote     = 8'h22;
    localparam logic [7:0] CharLBrace    = 8'h7B;
    localparam logic [7:0] CharLBracket  = 8'h5B;
    localparam logic [7:0] CharRBrace    = 8'h7D;
    localparam logic [7:0] CharRBracket  = 8'h5D;

    typedef enum logic [2:0] {
        STATUS_OK              = 3'd0,
        STATUS_TOO_LARGE       = 3'd1,
        STATUS_EMBEDDED_NUL    = 3'd2,
        STATUS_DEPTH_EXCEEDED  = 3'd3,
        STATUS_STRING_TOO_LONG = 3'd4
    } status_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_MAX_DOCUMENT_BYTES = 2'd0,
        CFG_MAX_STRING_BYTES   = 2'd1,
        CFG_MAX_NESTING_DEPTH  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [MaxDocWidth-1:0]   max_document_bytes;
        logic [MaxStrWidth-1:0]   max_string_bytes;
        logic [MaxDepthWidth-1:0] max_nesting_depth;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

endpackage

### design/jec_scan.sv
// ============================================================================
// jec_scan
// Document state registers and the per-byte scan logic.
// ============================================================================
module jec_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  jec_pkg::cfg_t     cfg,
    input  jec_pkg::item_t    item,
    input  logic              advance,
    output jec_pkg::status_t  status
);

    logic [jec_pkg::DocCountWidth-1:0] doc_count_reg, doc_count_next;
    logic [jec_pkg::StrCountWidth-1:0] str_count_reg, str_count_next;
    logic [jec_pkg::DepthWidth-1:0]    depth_reg, depth_next;
    logic                              in_str_reg, in_str_next;
    logic                              esc_reg, esc_next;
    jec_pkg::status_t                  err_reg, err_next;
    logic [jec_pkg::StrCountWidth-1:0] str_count_inc;
    logic [jec_pkg::DepthWidth-1:0]    depth_inc;

    assign str_count_inc = str_count_reg + 1'b1;
    assign depth_inc     = depth_reg + 1'b1;

    always_comb
    begin
        doc_count_next = (&doc_count_reg) ? doc_count_reg : doc_count_reg + 1'b1;
        str_count_next = str_count_reg;
        depth_next     = depth_reg;
        in_str_next    = in_str_reg;
        esc_next       = esc_reg;
        err_next       = err_reg;
        if (err_reg == jec_pkg::STATUS_OK)
        begin
            if (item.data_byte == jec_pkg::CharNul)
            begin
                err_next = jec_pkg::STATUS_EMBEDDED_NUL;
            end
            else if (in_str_reg)
            begin
                if (!esc_reg && item.data_byte == jec_pkg::CharQuote)
                begin
                    in_str_next = 1'b0;
                end
                else
                begin
                    esc_next       = !esc_reg && (item.data_byte == jec_pkg::CharBackslash);
                    str_count_next = str_count_inc;
                    if (str_count_inc > {1'b0, cfg.max_string_bytes})
                        err_next = jec_pkg::STATUS_STRING_TOO_LONG;
                end
            end
            else if (item.data_byte == jec_pkg::CharQuote)
            begin
                in_str_next    = 1'b1;
                esc_next       = 1'b0;
                str_count_next = '0;
            end
            else if (item.data_byte inside {jec_pkg::CharLBrace, jec_pkg::CharLBracket})
            begin
                depth_next = depth_inc;
                if (depth_inc > {1'b0, cfg.max_nesting_depth})
                    err_next = jec_pkg::STATUS_DEPTH_EXCEEDED;
            end
            else if (item.data_byte inside {jec_pkg::CharRBrace, jec_pkg::CharRBracket}
                     && depth_reg != '0)
            begin
                depth_next = depth_reg - 1'b1;
            end
        end
        if (doc_count_next > {1'b0, cfg.max_document_bytes})
            status = jec_pkg::STATUS_TOO_LARGE;
        else
            status = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            doc_count_reg <= '0;
            str_count_reg <= '0;
            depth_reg     <= '0;
            in_str_reg    <= 1'b0;
            esc_reg       <= 1'b0;
            err_reg       <= jec_pkg::STATUS_OK;
        end
        else if (advance)
        begin
            if (item.last_byte)
            begin
                doc_count_reg <= '0;
                str_count_reg <= '0;
                depth_reg     <= '0;
                in_str_reg    <= 1'b0;
                esc_reg       <= 1'b0;
                err_reg       <= jec_pkg::STATUS_OK;
            end
            else
            begin
                doc_count_reg <= doc_count_next;
                str_count_reg <= str_count_next;
                depth_reg     <= depth_next;
                in_str_reg    <= in_str_next;
                esc_reg       <= esc_next;
                err_reg       <= err_next;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last_byte |=>
            doc_count_reg == '0 && depth_reg == '0 && err_reg == jec_pkg::STATUS_OK)
        else $error("document state not cleared after final byte");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !item.last_byte && err_reg != jec_pkg::STATUS_OK |=>
            err_reg == $past(err_reg) && depth_reg == $past(depth_reg))
        else $error("content error or depth changed after first error");

    a_doc_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !item.last_byte && !(&doc_count_reg) |=>
            doc_count_reg == $past(doc_count_reg) + 1'b1)
        else $error("document byte count did not advance");

    a_escape_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> in_str_reg)
        else $error("escape pending outside a string");

endmodule

### design/jec_out.sv
// ============================================================================
// jec_out
// Result register holding one status word for the downstream side.
// ============================================================================
module jec_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jec_pkg::status_t  status_in,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status_code
);

    logic             valid_reg;
    jec_pkg::status_t status_reg;

    assign free        = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign status_code = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            status_reg <= status_in;
    end

endmodule

### design/json_envelope_byte_checker_top.sv
// ============================================================================
// json_envelope_byte_checker_top
// JSON envelope byte checker: one status word per document.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready, data_byte, last_byte) takes one byte of
//   the document per word; last_byte marks the final byte. Output channel
//   (out_valid/out_ready, status_code) returns one status word per document,
//   only for the final byte.
//   Each byte waits in the input register, where the scan logic
//   updates the document state; a final byte loads the result register.
//   The status passes through the input register and then the result
//   register before it is offered on the output channel.
//   Throughput: one byte per cycle, bounded by the input register handing
//   off to the state registers and by final bytes that wait (see below).
//   When the receiver stalls with a status pending, non-final bytes still
//   flow; a following final byte waits in the input register until the
//   result register frees up. Reset clears document state, the pipeline
//   valids and sets the limit registers to their defaults. Limits are
//   written through cfg_write, cfg_index and cfg_data by the user only
//   while no document is in flight; the block itself does not enforce it.
// ============================================================================
module json_envelope_byte_checker_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [jec_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [jec_pkg::CfgDataWidth-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          data_byte,
    input  logic                                last_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          status_code
);

    jec_pkg::cfg_t    cfg_reg;
    jec_pkg::item_t   item_reg;
    logic             item_valid_reg;
    logic             advance;
    logic             out_free;
    jec_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_document_bytes <= jec_pkg::MaxDocReset;
            cfg_reg.max_string_bytes   <= jec_pkg::MaxStrReset;
            cfg_reg.max_nesting_depth  <= jec_pkg::MaxDepthReset;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                jec_pkg::CFG_MAX_DOCUMENT_BYTES:
                    cfg_reg.max_document_bytes <= cfg_data[jec_pkg::MaxDocWidth-1:0];
                jec_pkg::CFG_MAX_STRING_BYTES:
                    cfg_reg.max_string_bytes <= cfg_data[jec_pkg::MaxStrWidth-1:0];
                jec_pkg::CFG_MAX_NESTING_DEPTH:
                    cfg_reg.max_nesting_depth <= cfg_data[jec_pkg::MaxDepthWidth-1:0];
                default:
                    ;
            endcase
        end
    end

    assign advance  = item_valid_reg && (!item_reg.last_byte || out_free);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.data_byte <= data_byte;
            item_reg.last_byte <= last_byte;
        end
    end

    jec_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .advance (advance),
        .status  (status)
    );

    jec_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && item_reg.last_byte),
        .status_in   (status),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status_code (status_code)
    );

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("input register lost a stalled byte");

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.last_byte |=> out_valid)
        else $error("final byte advanced without loading a status");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> !$past(advance && item_reg.last_byte))
        else $error("status loaded over a pending one");

endmodule
